### rtl/rrp_pkg.sv
// types and constants shared by the register response parser files
`default_nettype none

package rrp_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WIDX_W   = 4;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned WCNT_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WCNT_W-1:0] MAX_WORDS = 5'd16;

  // operation codes
  localparam logic [OP_W-1:0] OP_START_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_START_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_RX_BYTE     = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_READ  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WRITE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ERR   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_READ_ACK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ACK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SUCC  = 2'd2;

  localparam logic [BYTE_W-1:0] READ_ACK_RST   = 8'd187;
  localparam logic [BYTE_W-1:0] WRITE_ACK_RST  = 8'd238;
  localparam logic [BYTE_W-1:0] WRITE_SUCC_RST = 8'd1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_LENGTH,
    PH_DATA,
    PH_RESULT,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [1:0] {
    SQ_ACCEPT,
    SQ_READ,
    SQ_EMIT
  } seq_e;

endpackage

`default_nettype wire

### rtl/rrp_if.sv
// valid/ready channel interfaces for the parser input and result streams
`default_nettype none

interface rrp_in_if import rrp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface rrp_out_if import rrp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic                     word_valid;
  logic [WIDX_W-1:0]        word_index;
  logic signed [WORD_W-1:0] word_value;
  logic                     last;

  modport source (output valid, output status, output word_valid, output word_index,
                  output word_value, output last, input ready);
  modport sink   (input valid, input status, input word_valid, input word_index,
                  input word_value, input last, output ready);
endinterface

`default_nettype wire

### rtl/register_response_parser_unit.sv
// register response parser: header/length checks, payload store and word drain
// a status result is registered straight from its accepted input beat
// a finishing read drains its words in turn (store read, then emit; emit waits
// while the output is held), and no input beat is taken until the last word
// is emitted; reset clears control state and loads configuration reset values;
// the store is not cleared and needs no clearing pass as a read returns only current-reply bytes
`default_nettype none

module register_response_parser_unit import rrp_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  rrp_in_if.sink               req_i,
  rrp_out_if.source            rsp_o,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [BYTE_W-1:0]     cfg_data_i
);

  localparam int unsigned ROWS   = (BUFFER_DEPTH + 1) / 2;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned FILL_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CMP_W  = (FILL_W > WCNT_W) ? FILL_W : WCNT_W;

  // configuration
  logic [BYTE_W-1:0] read_ack_q, write_ack_q, write_succ_q;

  // control state
  phase_e            phase_q, phase_d;
  seq_e              seq_q, seq_d;
  logic              is_write_q, is_write_d;
  logic [BYTE_W-1:0] bytes_left_q, bytes_left_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [WIDX_W-1:0] k_q, k_d;
  logic [WCNT_W-1:0] nwords_q, nwords_d;

  // result register
  logic                     out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]      out_status_q, out_status_d;
  logic                     out_wvalid_q, out_wvalid_d;
  logic [WIDX_W-1:0]        out_widx_q, out_widx_d;
  logic [WORD_W-1:0]        out_word_q, out_word_d;
  logic                     out_last_q, out_last_d;

  // payload store, one byte lane per array
  logic [BYTE_W-1:0] mem_lo [ROWS];
  logic [BYTE_W-1:0] mem_hi [ROWS];
  logic [BYTE_W-1:0] rd_lo_q, rd_hi_q;
  logic              wr_en;
  logic [ROW_W-1:0]  wr_row;
  logic [ROW_W-1:0]  rd_row;

  logic              out_free;
  logic              in_acc;
  logic [FILL_W-1:0] fill_inc;
  logic [FILL_W:0]   half_up;
  logic [CMP_W-1:0]  hi_pos;
  logic              hi_ok;

  assign out_free  = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (seq_q == SQ_ACCEPT) && out_free;
  assign in_acc    = req_i.valid && req_i.ready;

  assign fill_inc = fill_q + FILL_W'(1);
  assign half_up  = ({1'b0, fill_inc} + (FILL_W+1)'(1)) >> 1;
  assign wr_row   = ROW_W'(fill_q >> 1);
  assign rd_row   = ROW_W'(k_q);
  assign wr_en    = in_acc && (req_i.operation == OP_RX_BYTE) && (phase_q == PH_DATA)
                    && (fill_q < FILL_W'(BUFFER_DEPTH));

  // high byte of word k exists only if 2k+1 lies inside the payload
  assign hi_pos = CMP_W'({k_q, 1'b1});
  assign hi_ok  = hi_pos < CMP_W'(fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_ack_q   <= READ_ACK_RST;
      write_ack_q  <= WRITE_ACK_RST;
      write_succ_q <= WRITE_SUCC_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_READ_ACK:   read_ack_q   <= cfg_data_i;
        CFG_WRITE_ACK:  write_ack_q  <= cfg_data_i;
        CFG_WRITE_SUCC: write_succ_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (fill_q[0]) begin
        mem_hi[wr_row] <= req_i.rx_byte;
      end else begin
        mem_lo[wr_row] <= req_i.rx_byte;
      end
    end
    if (seq_q == SQ_READ) begin
      rd_lo_q <= mem_lo[rd_row];
      rd_hi_q <= mem_hi[rd_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      seq_q        <= SQ_ACCEPT;
      is_write_q   <= 1'b0;
      bytes_left_q <= '0;
      fill_q       <= '0;
      k_q          <= '0;
      nwords_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      seq_q        <= seq_d;
      is_write_q   <= is_write_d;
      bytes_left_q <= bytes_left_d;
      fill_q       <= fill_d;
      k_q          <= k_d;
      nwords_q     <= nwords_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_wvalid_q <= out_wvalid_d;
    out_widx_q   <= out_widx_d;
    out_word_q   <= out_word_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    phase_d      = phase_q;
    seq_d        = seq_q;
    is_write_d   = is_write_q;
    bytes_left_d = bytes_left_q;
    fill_d       = fill_q;
    k_d          = k_q;
    nwords_d     = nwords_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_wvalid_d = out_wvalid_q;
    out_widx_d   = out_widx_q;
    out_word_d   = out_word_q;
    out_last_d   = out_last_q;

    case (seq_q)
      SQ_ACCEPT: begin
        if (in_acc) begin
          // default: one status beat
          out_valid_d  = 1'b1;
          out_status_d = ST_BUSY;
          out_wvalid_d = 1'b0;
          out_widx_d   = '0;
          out_word_d   = '0;
          out_last_d   = 1'b1;
          if (req_i.operation == OP_START_READ || req_i.operation == OP_START_WRITE) begin
            is_write_d   = (req_i.operation == OP_START_WRITE);
            phase_d      = PH_HEADER;
            bytes_left_d = '0;
            fill_d       = '0;
          end else if (req_i.operation == OP_RX_BYTE) begin
            case (phase_q)
              PH_HEADER: begin
                if (req_i.rx_byte == (is_write_q ? write_ack_q : read_ack_q)) begin
                  phase_d = is_write_q ? PH_RESULT : PH_LENGTH;
                end else begin
                  phase_d      = PH_ERROR;
                  out_status_d = ST_ERR;
                end
              end
              PH_LENGTH: begin
                if (req_i.rx_byte == '0 ||
                    {1'b0, req_i.rx_byte} > (BYTE_W+1)'(BUFFER_DEPTH)) begin
                  phase_d      = PH_ERROR;
                  out_status_d = ST_ERR;
                end else begin
                  bytes_left_d = req_i.rx_byte;
                  fill_d       = '0;
                  phase_d      = PH_DATA;
                end
              end
              PH_DATA: begin
                fill_d       = fill_inc;
                bytes_left_d = bytes_left_q - BYTE_W'(1);
                if (bytes_left_q == BYTE_W'(1)) begin
                  // last payload byte: start draining words instead of a status beat
                  phase_d     = PH_DONE;
                  out_valid_d = out_valid_q && !rsp_o.ready;
                  seq_d       = SQ_READ;
                  k_d         = '0;
                  nwords_d    = (half_up > (FILL_W+1)'(MAX_WORDS)) ? MAX_WORDS
                                                                  : WCNT_W'(half_up);
                end
              end
              PH_RESULT: begin
                if (req_i.rx_byte == write_succ_q) begin
                  phase_d      = PH_DONE;
                  out_status_d = ST_WRITE;
                end else begin
                  phase_d      = PH_ERROR;
                  out_status_d = ST_ERR;
                end
              end
              default: ;
            endcase
          end
        end
      end
      SQ_READ: begin
        seq_d = SQ_EMIT;
      end
      SQ_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_READ;
          out_wvalid_d = 1'b1;
          out_widx_d   = k_q;
          out_word_d   = {(hi_ok ? rd_hi_q : BYTE_W'(0)), rd_lo_q};
          out_last_d   = (WCNT_W'(k_q) + WCNT_W'(1)) == nwords_q;
          k_d          = k_q + WIDX_W'(1);
          seq_d        = out_last_d ? SQ_ACCEPT : SQ_READ;
        end
      end
      default: begin
        seq_d = SQ_ACCEPT;
      end
    endcase
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.word_valid = out_wvalid_q;
  assign rsp_o.word_index = out_widx_q;
  assign rsp_o.word_value = out_word_q;
  assign rsp_o.last       = out_last_q;

`ifndef SYNTHESIS
  a_drain_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != SQ_ACCEPT) |-> (phase_q == PH_DONE))
    else $error("word drain outside a finished read");

  a_drain_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != SQ_ACCEPT) |-> (WCNT_W'(k_q) < nwords_q))
    else $error("word index beyond word count");

  a_word_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.word_valid) |-> (rsp_o.status == ST_READ))
    else $error("data word without read status");

  a_no_input_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_READ) |=> (seq_q == SQ_EMIT) && !req_i.ready)
    else $error("input taken during word drain");
`endif

endmodule

`default_nettype wire
